FILE: rtl/assert_macros.svh
// Assertion macros shared by the point group classifier RTL.
// Needs nothing else; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/pgc_pkg.sv
// Shared types and constants for the point group classifier.
// Beat structs, opcode and group code enums, dot product limits.
// Depends on nothing.
package pgc_pkg;

	localparam int COUNT_W_DEFAULT = 8;
	localparam int ORDER_W = 8;
	localparam int DIR_W = 16;
	localparam int DIR_FRAC = DIR_W - 2;
	localparam int PROD_W = 2 * DIR_W;
	localparam int SUM_W = PROD_W + 2;

	// Limits on |dot| with 2*DIR_FRAC fraction bits, floored
	localparam logic [SUM_W-1:0] UNIT_SQ = SUM_W'(1) << (2 * DIR_FRAC);
	localparam logic [SUM_W-1:0] LIM_LOW = SUM_W'((UNIT_SQ * 3) / 10);
	localparam logic [SUM_W-1:0] LIM_HIGH = SUM_W'((UNIT_SQ * 7) / 10);

	typedef enum logic [1:0] {
		OP_AXIS = 2'd0,
		OP_PLANE = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		GC_IH = 4'd0,
		GC_I = 4'd1,
		GC_OH = 4'd2,
		GC_O = 4'd3,
		GC_TD = 4'd4,
		GC_TH = 4'd5,
		GC_T = 4'd6,
		GC_CS = 4'd7,
		GC_CI = 4'd8,
		GC_C1 = 4'd9,
		GC_DNH = 4'd10,
		GC_DND = 4'd11,
		GC_DN = 4'd12,
		GC_CNH = 4'd13,
		GC_CNV = 4'd14,
		GC_CN = 4'd15
	} group_code_t;

	typedef struct packed {
		logic [1:0] op;
		logic [ORDER_W-1:0] axis_order;
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_z;
		logic inversion_present;
	} item_t;

	typedef struct packed {
		group_code_t group_code;
		logic [ORDER_W-1:0] principal_order;
	} result_t;

endpackage

FILE: rtl/point_group_classifier.sv
// Point group classifier: folds symmetry element beats into counts and
// returns a Schoenflies family code on the finish beat.
// Depends on pgc_pkg and assert_macros.svh.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------
//   item    | item_valid/item_stall  | pgc_pkg::item_t (element in)
//   result  | result_valid/result_stall | pgc_pkg::result_t (family)
//
// One beat per cycle is taken while item_stall is low; an accepted finish
// beat passes the input, product and result registers before result_valid rises.
// The three dot product multipliers sit between the input and product
// registers; the sum, limit compare and counter update follow them.
// Reset clears the principal axis, all counts and both pipeline valids.
// item_stall rises only while a finish beat waits behind a stalled result.
`include "assert_macros.svh"

module point_group_classifier #(
	parameter int COUNT_WIDTH = pgc_pkg::COUNT_W_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  pgc_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output pgc_pkg::result_t  result
);

	localparam int OW = pgc_pkg::ORDER_W;
	localparam int DW = pgc_pkg::DIR_W;
	localparam int PW = pgc_pkg::PROD_W;
	localparam int SW = pgc_pkg::SUM_W;
	localparam int CMP_W = (COUNT_WIDTH > OW) ? COUNT_WIDTH : OW;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		sat_inc = (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

	// Stage 1: input register
	logic             valid_s1;
	pgc_pkg::item_t   item_s1;

	// Stage 2: products and carried fields
	logic                  valid_s2;
	logic [1:0]            op_s2;
	logic [OW-1:0]         ord_s2;
	logic                  inv_s2;
	logic [OW-1:0]         n_s2;
	logic signed [PW-1:0]  px_s2, py_s2, pz_s2;

	// Principal axis
	logic signed [DW-1:0]  principal_x_q, principal_y_q, principal_z_q;
	logic [OW-1:0]         highest_q;
	logic                  principal_seen_q;

	// Counts
	logic [COUNT_WIDTH-1:0] c3_q, c4_q, c5_q, perp_q, plane_q, vert_q;
	logic                   hseen_q;

	// Result register
	logic              res_valid_q;
	pgc_pkg::result_t  res_q;

	logic hold_s2, fire_s1, fire_s2, fin_s2;
	logic signed [DW-1:0] pr_x, pr_y, pr_z;
	logic signed [SW-1:0] dot_sum;
	logic [SW-1:0]        dot_abs;
	logic                 is_low, is_high;
	pgc_pkg::group_code_t code;

	assign fin_s2     = (op_s2 == pgc_pkg::OP_FINISH);
	assign hold_s2    = valid_s2 && fin_s2 && res_valid_q && result_stall;
	assign fire_s1    = valid_s1 && !hold_s2;
	assign fire_s2    = valid_s2 && !hold_s2;
	assign item_stall = hold_s2;

	// The first axis is compared with its own direction
	always_comb begin
		if (item_s1.op == pgc_pkg::OP_AXIS && !principal_seen_q) begin
			pr_x = item_s1.dir_x;
			pr_y = item_s1.dir_y;
			pr_z = item_s1.dir_z;
		end else begin
			pr_x = principal_x_q;
			pr_y = principal_y_q;
			pr_z = principal_z_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (!hold_s2) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !hold_s2) begin
			item_s1 <= item;
		end
		if (fire_s1) begin
			op_s2  <= item_s1.op;
			ord_s2 <= item_s1.axis_order;
			inv_s2 <= item_s1.inversion_present;
			n_s2   <= highest_q;
			px_s2  <= item_s1.dir_x * pr_x;
			py_s2  <= item_s1.dir_y * pr_y;
			pz_s2  <= item_s1.dir_z * pr_z;
		end
	end

	// Principal axis: take the first axis, drop it on finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			principal_x_q    <= '0;
			principal_y_q    <= '0;
			principal_z_q    <= '0;
			highest_q        <= OW'(1);
			principal_seen_q <= 1'b0;
		end else if (fire_s1) begin
			if (item_s1.op == pgc_pkg::OP_AXIS && !principal_seen_q) begin
				principal_x_q    <= item_s1.dir_x;
				principal_y_q    <= item_s1.dir_y;
				principal_z_q    <= item_s1.dir_z;
				highest_q        <= item_s1.axis_order;
				principal_seen_q <= 1'b1;
			end else if (item_s1.op == pgc_pkg::OP_FINISH) begin
				principal_x_q    <= '0;
				principal_y_q    <= '0;
				principal_z_q    <= '0;
				highest_q        <= OW'(1);
				principal_seen_q <= 1'b0;
			end
		end
	end

	assign dot_sum = SW'(px_s2) + SW'(py_s2) + SW'(pz_s2);
	assign dot_abs = dot_sum[SW-1] ? SW'(-dot_sum) : SW'(dot_sum);
	assign is_low  = (dot_abs <= pgc_pkg::LIM_LOW);
	assign is_high = (dot_abs > pgc_pkg::LIM_HIGH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c3_q    <= '0;
			c4_q    <= '0;
			c5_q    <= '0;
			perp_q  <= '0;
			plane_q <= '0;
			vert_q  <= '0;
			hseen_q <= 1'b0;
		end else if (fire_s2) begin
			unique case (op_s2)
				pgc_pkg::OP_AXIS: begin
					if (ord_s2 == OW'(3)) c3_q <= sat_inc(c3_q);
					if (ord_s2 == OW'(4)) c4_q <= sat_inc(c4_q);
					if (ord_s2 == OW'(5)) c5_q <= sat_inc(c5_q);
					if (ord_s2 == OW'(2) && is_low) perp_q <= sat_inc(perp_q);
				end
				pgc_pkg::OP_PLANE: begin
					plane_q <= sat_inc(plane_q);
					if (is_low) vert_q <= sat_inc(vert_q);
					if (is_high) hseen_q <= 1'b1;
				end
				pgc_pkg::OP_FINISH: begin
					c3_q    <= '0;
					c4_q    <= '0;
					c5_q    <= '0;
					perp_q  <= '0;
					plane_q <= '0;
					vert_q  <= '0;
					hseen_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		priority if (c5_q >= COUNT_WIDTH'(6)) begin
			code = inv_s2 ? pgc_pkg::GC_IH : pgc_pkg::GC_I;
		end else if (c4_q >= COUNT_WIDTH'(3)) begin
			code = inv_s2 ? pgc_pkg::GC_OH : pgc_pkg::GC_O;
		end else if (c3_q >= COUNT_WIDTH'(4) && n_s2 <= OW'(3)) begin
			if (plane_q >= COUNT_WIDTH'(6)) code = pgc_pkg::GC_TD;
			else code = inv_s2 ? pgc_pkg::GC_TH : pgc_pkg::GC_T;
		end else if (n_s2 == OW'(1)) begin
			if (plane_q != '0) code = pgc_pkg::GC_CS;
			else code = inv_s2 ? pgc_pkg::GC_CI : pgc_pkg::GC_C1;
		end else if (CMP_W'(perp_q) >= CMP_W'(n_s2)) begin
			if (hseen_q) code = pgc_pkg::GC_DNH;
			else if (CMP_W'(vert_q) >= CMP_W'(n_s2)) code = pgc_pkg::GC_DND;
			else code = pgc_pkg::GC_DN;
		end else begin
			if (hseen_q) code = pgc_pkg::GC_CNH;
			else if (vert_q != '0) code = pgc_pkg::GC_CNV;
			else code = pgc_pkg::GC_CN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s2 && fin_s2) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s2 && fin_s2) begin
			res_q.group_code      <= code;
			res_q.principal_order <= n_s2;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	`ASSERT_NEXT(a_result_after_finish, clk, arst_n, fire_s2 && fin_s2, result_valid)
	`ASSERT_NEXT(a_principal_cleared, clk, arst_n, fire_s1 && item_s1.op == pgc_pkg::OP_FINISH, !principal_seen_q && highest_q == OW'(1))
	`ASSERT_NEXT(a_counts_cleared, clk, arst_n, fire_s2 && fin_s2, plane_q == '0 && vert_q == '0 && perp_q == '0 && !hseen_q)
	`ASSERT_IMPL(a_stall_needs_blocked_result, clk, arst_n, item_stall, result_valid && result_stall)

endmodule

FILE: verif/tb.sv
// Self-checking testbench for point_group_classifier: directed and random
// symmetry element beats, with a predictor and an in-order result check.
// Depends on pgc_pkg and the point_group_classifier RTL.
module tb;
	import pgc_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int UNIT = 16384;
	localparam int VERT_EDGE = 4915;   // last |w| that still counts as perpendicular
	localparam int HORZ_EDGE = 11468;  // last |w| that is not yet horizontal
	localparam int RANDOM_BEATS = 650;

	typedef struct {
		item_t beat;
		bit drain;
	} feed_entry_t;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;

	point_group_classifier DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	feed_entry_t element_feed[$];
	result_t awaited_families[$];
	int mismatches = 0;

	// Predictor copy of the element tally
	logic signed [DIR_W-1:0] prin_x, prin_y, prin_z;
	logic [ORDER_W-1:0] top_order;
	logic have_principal;
	logic [7:0] n3, n4, n5, perp2, planes, vplanes;
	logic hplane;

	longint lim_perp, lim_horz;

	task automatic clear_tally();
		prin_x = '0;
		prin_y = '0;
		prin_z = '0;
		top_order = 8'd1;
		have_principal = 1'b0;
		n3 = '0;
		n4 = '0;
		n5 = '0;
		perp2 = '0;
		planes = '0;
		vplanes = '0;
		hplane = 1'b0;
	endtask

	function automatic logic [7:0] bump(input logic [7:0] c);
		return (c == 8'hFF) ? c : c + 8'd1;
	endfunction

	function automatic longint dot_mag(input item_t b);
		longint s;
		s = longint'($signed(b.dir_x)) * longint'(prin_x)
			+ longint'($signed(b.dir_y)) * longint'(prin_y)
			+ longint'($signed(b.dir_z)) * longint'(prin_z);
		return (s < 0) ? -s : s;
	endfunction

	task automatic absorb_element(input item_t b);
		longint m;
		result_t r;
		logic [ORDER_W-1:0] n;
		case (b.op)
			OP_AXIS: begin
				if (!have_principal) begin
					prin_x = b.dir_x;
					prin_y = b.dir_y;
					prin_z = b.dir_z;
					top_order = b.axis_order;
					have_principal = 1'b1;
				end
				if (b.axis_order == 8'd3) n3 = bump(n3);
				if (b.axis_order == 8'd4) n4 = bump(n4);
				if (b.axis_order == 8'd5) n5 = bump(n5);
				if (b.axis_order == 8'd2 && dot_mag(b) <= lim_perp) perp2 = bump(perp2);
			end
			OP_PLANE: begin
				planes = bump(planes);
				m = dot_mag(b);
				if (m > lim_horz) hplane = 1'b1;
				if (m <= lim_perp) vplanes = bump(vplanes);
			end
			OP_FINISH: begin
				n = top_order;
				if (n5 >= 8'd6)
					r.group_code = b.inversion_present ? GC_IH : GC_I;
				else if (n4 >= 8'd3)
					r.group_code = b.inversion_present ? GC_OH : GC_O;
				else if (n3 >= 8'd4 && n <= 8'd3)
					r.group_code = (planes >= 8'd6) ? GC_TD
						: (b.inversion_present ? GC_TH : GC_T);
				else if (n == 8'd1)
					r.group_code = (planes != 0) ? GC_CS
						: (b.inversion_present ? GC_CI : GC_C1);
				else if (perp2 >= n)
					r.group_code = hplane ? GC_DNH : (vplanes >= n ? GC_DND : GC_DN);
				else
					r.group_code = hplane ? GC_CNH : (vplanes != 0 ? GC_CNV : GC_CN);
				r.principal_order = n;
				awaited_families.push_back(r);
				clear_tally();
			end
			default: ;  // spare opcode: drop
		endcase
	endtask

	// Stimulus building
	bit drain_next = 1'b0;
	bit in_random = 1'b0;
	int random_beats = 0;
	int axis_sel = 2;
	bit axis_neg = 1'b0;
	item_t body[$];

	function automatic item_t beat_of(input logic [1:0] op, input int ord,
			input int x, input int y, input int z, input logic inv);
		item_t b;
		b.op = op;
		b.axis_order = ORDER_W'(ord);
		b.dir_x = DIR_W'(x);
		b.dir_y = DIR_W'(y);
		b.dir_z = DIR_W'(z);
		b.inversion_present = inv;
		return b;
	endfunction

	// Place w along the current principal direction, u and v across it
	function automatic item_t oriented(input logic [1:0] op, input int ord,
			input int u, input int v, input int w);
		int c[3];
		c[axis_sel] = axis_neg ? -w : w;
		c[(axis_sel + 1) % 3] = u;
		c[(axis_sel + 2) % 3] = v;
		return beat_of(op, ord, c[0], c[1], c[2], $urandom_range(0, 1));
	endfunction

	function automatic int tilt(input int edge_val);
		int w;
		case ($urandom_range(0, 3))
			0: w = edge_val;
			1: w = edge_val + 1;
			2: w = $urandom_range(0, edge_val);
			default: w = $urandom_range(0, UNIT);
		endcase
		return $urandom_range(0, 1) ? -w : w;
	endfunction

	function automatic int any_comp();
		return int'($signed(16'($urandom)));
	endfunction

	function automatic int cross_comp();
		return $urandom_range(0, 2 * UNIT) - UNIT;
	endfunction

	task automatic push_beat(input item_t b);
		feed_entry_t e;
		e.beat = b;
		e.drain = drain_next;
		drain_next = 1'b0;
		element_feed.push_back(e);
		if (in_random) random_beats++;
	endtask

	task automatic flush_body(input bit scramble, input logic inv);
		item_t t;
		int j;
		if (scramble)
			for (int i = 0; i < body.size(); i++) begin
				j = $urandom_range(0, body.size() - 1);
				t = body[i];
				body[i] = body[j];
				body[j] = t;
			end
		foreach (body[i]) push_beat(body[i]);
		push_beat(beat_of(OP_FINISH, $urandom_range(0, 255), any_comp(), any_comp(),
			any_comp(), inv));
		body.delete();
	endtask

	task automatic build_directed();
		// empty set, with and without inversion
		push_beat(beat_of(OP_FINISH, 0, 0, 0, 0, 1'b0));
		push_beat(beat_of(OP_FINISH, 255, -32768, 32767, -1, 1'b1));
		// plane before any axis
		push_beat(beat_of(OP_PLANE, 0, 0, 0, UNIT, 1'b0));
		push_beat(beat_of(OP_FINISH, 0, 0, 0, 0, 1'b0));
		// spare opcode with every bit set, then with every bit clear
		push_beat(beat_of(OP_SPARE, 255, -1, -1, -1, 1'b1));
		// order-2 first axis compared with itself, horizontal plane
		push_beat(beat_of(OP_AXIS, 2, 0, 0, UNIT, 1'b0));
		push_beat(beat_of(OP_SPARE, 0, 0, 0, 0, 1'b0));
		push_beat(beat_of(OP_PLANE, 0, 0, 0, UNIT, 1'b0));
		push_beat(beat_of(OP_FINISH, 0, 0, 0, 0, 1'b0));
		// order zero axis, extreme components
		push_beat(beat_of(OP_AXIS, 0, -32768, -32768, -32768, 1'b1));
		push_beat(beat_of(OP_PLANE, 0, 32767, 32767, 32767, 1'b0));
		push_beat(beat_of(OP_FINISH, 0, 0, 0, 0, 1'b1));
		// order 255 axis, non-unit direction
		push_beat(beat_of(OP_AXIS, 255, 32767, -32768, 32767, 1'b0));
		push_beat(beat_of(OP_AXIS, 2, UNIT, 0, 0, 1'b0));
		push_beat(beat_of(OP_FINISH, 0, 0, 0, 0, 1'b0));
		// plane first, then the axes
		push_beat(beat_of(OP_PLANE, 0, UNIT, 0, 0, 1'b1));
		push_beat(beat_of(OP_AXIS, 3, 0, 0, UNIT, 1'b0));
		push_beat(beat_of(OP_AXIS, 2, UNIT, 0, VERT_EDGE + 1, 1'b0));
		push_beat(beat_of(OP_AXIS, 2, 0, UNIT, -VERT_EDGE, 1'b0));
		push_beat(beat_of(OP_PLANE, 0, 0, UNIT, HORZ_EDGE, 1'b0));
		push_beat(beat_of(OP_FINISH, 0, 0, 0, 0, 1'b1));
	endtask

	task automatic build_random();
		int seq_no;
		int n, k;
		bit saturated;
		seq_no = 0;
		saturated = 1'b0;
		in_random = 1'b1;
		drain_next = 1'b1;
		while (random_beats < RANDOM_BEATS) begin
			seq_no++;
			if (seq_no % 12 == 0) drain_next = 1'b1;
			axis_sel = $urandom_range(0, 2);
			axis_neg = $urandom_range(0, 1);
			if (!saturated && random_beats > 150) begin
				// push the perpendicular C2 count into saturation at n = 255
				saturated = 1'b1;
				body.push_back(oriented(OP_AXIS, 255, 0, 0, UNIT));
				k = 256 + $urandom_range(0, 3);
				repeat (k) body.push_back(oriented(OP_AXIS, 2, cross_comp(), cross_comp(), 0));
				repeat (2) body.push_back(oriented(OP_PLANE, 0, cross_comp(), cross_comp(), 0));
				flush_body(1'b0, $urandom_range(0, 1));
				continue;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					// axial molecule: principal, perpendicular C2s, planes
					if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 1) ? 0 : 255;
					else n = $urandom_range(1, 8);
					body.push_back(oriented(OP_AXIS, n, 0, 0, UNIT));
					if (n > 8) k = $urandom_range(0, 3);
					else k = $urandom_range(0, 1) ? n : $urandom_range(0, n + 1);
					repeat (k) body.push_back(oriented(OP_AXIS, 2, cross_comp(), cross_comp(),
						tilt(VERT_EDGE)));
					if ($urandom_range(0, 1))
						body.push_back(oriented(OP_PLANE, 0, cross_comp(), cross_comp(),
							tilt(HORZ_EDGE)));
					if (n > 8) k = $urandom_range(0, 3);
					else k = $urandom_range(0, 1) ? n : $urandom_range(0, n + 1);
					repeat (k) body.push_back(oriented(OP_PLANE, 0, cross_comp(), cross_comp(),
						tilt(VERT_EDGE)));
					flush_body($urandom_range(0, 5) == 0, $urandom_range(0, 1));
				end
				5, 6, 7: begin
					// cubic or icosahedral style sets
					body.push_back(oriented(OP_AXIS, $urandom_range(2, 6), 0, 0, UNIT));
					repeat ($urandom_range(0, 7)) body.push_back(oriented(OP_AXIS, 5,
						cross_comp(), cross_comp(), cross_comp()));
					repeat ($urandom_range(0, 4)) body.push_back(oriented(OP_AXIS, 4,
						cross_comp(), cross_comp(), cross_comp()));
					repeat ($urandom_range(0, 6)) body.push_back(oriented(OP_AXIS, 3,
						cross_comp(), cross_comp(), cross_comp()));
					repeat ($urandom_range(0, 3)) body.push_back(oriented(OP_AXIS, 2,
						cross_comp(), cross_comp(), tilt(VERT_EDGE)));
					repeat ($urandom_range(0, 8)) body.push_back(oriented(OP_PLANE, 0,
						cross_comp(), cross_comp(), cross_comp()));
					flush_body($urandom_range(0, 4) == 0, $urandom_range(0, 1));
				end
				default: begin
					// noise: any opcode, any field value
					repeat ($urandom_range(1, 8))
						push_beat(beat_of(2'($urandom_range(0, 3)), $urandom_range(0, 255),
							any_comp(), any_comp(), any_comp(), $urandom_range(0, 1)));
				end
			endcase
		end
		push_beat(beat_of(OP_FINISH, 0, 0, 0, 0, $urandom_range(0, 1)));
	endtask

	// Sender: bursts with random gaps, optional drain before a marked beat
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				absorb_element(item);
			if (item_valid && item_stall) begin
				// hold the stalled beat
			end else if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (element_feed.size() == 0) begin
				item_valid <= 1'b0;
			end else if (element_feed[0].drain && awaited_families.size() != 0) begin
				item_valid <= 1'b0;
			end else begin
				item <= element_feed[0].beat;
				item_valid <= 1'b1;
				void'(element_feed.pop_front());
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// Receiver: stall pattern changes mode every so often
	int stall_tick = 0;
	int stall_mode = 0;
	result_t want;

	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (awaited_families.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual code %0d order %0d",
						$time, result.group_code, result.principal_order);
					mismatches++;
				end else begin
					want = awaited_families.pop_front();
					if (result.group_code !== want.group_code) begin
						$display("%0t: group_code mismatch, expected %0d actual %0d",
							$time, want.group_code, result.group_code);
						mismatches++;
					end
					if (result.principal_order !== want.principal_order) begin
						$display("%0t: principal_order mismatch, expected %0d actual %0d",
							$time, want.principal_order, result.principal_order);
						mismatches++;
					end
				end
			end
			stall_tick++;
			if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= ($urandom_range(0, 3) != 0);
				default: result_stall <= stall_tick[3];
			endcase
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		lim_perp = (64'd3 << (2 * (DIR_W - 2))) / 10;
		lim_horz = (64'd7 << (2 * (DIR_W - 2))) / 10;
		clear_tally();
		build_directed();
		build_random();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// sample on the falling edge, once the sender and receiver have settled
		while (element_feed.size() != 0 || item_valid || awaited_families.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#500000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pgc_pkg.sv
rtl/point_group_classifier.sv
verif/tb.sv
